// File: rtl/core/mmss_pkg.sv
// Package for the minutes:seconds countdown timer.
// Request codes, digit-entry constants and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package mmss_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_KEY   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] TENS_LIMIT  = 8'd6;
  localparam logic [7:0] UNITS_LIMIT = 8'd10;
  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [2:0] DIGIT_COUNT = 3'd4;
  localparam logic [2:0] POS_SECONDS = 3'd2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Packed from the lowest bit: minutes, seconds, done_res, buzzer_pin,
  // digits_entered, key_accepted.
  typedef struct packed {
    logic       key_accepted;
    logic [2:0] digits_entered;
    logic       buzzer_pin;
    logic       done_res;
    logic [5:0] seconds;
    logic [5:0] minutes;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// File: rtl/core/mm_ss_countdown_timer.sv
// Minutes:seconds countdown timer, top level.
// Uses mmss_pkg for request codes, constants and the result record.
// Timer state, per-item update logic and a two-entry output buffer.
`timescale 1ns / 1ps

// Usage:
//   Input stream (in_*): one item per transfer. in_tuser carries the request
//   kind (tick, key press, clear); in_tdata carries key_code and paused.
//   Output stream (out_*): exactly one result per input item, in order, with
//   the time left, done flag, buzzer pin level, digit count and key status.
//   Each result is registered, in the skid entry while the output register waits.
//   Throughput: one item per cycle while in_tready is high; the state
//   update is a single pass of narrow add/compare logic between the timer
//   registers and the result register.
//   Stall: a result register plus one skid entry; input keeps flowing while
//   one result waits, and in_tready drops only once the skid entry is full.
//   Reset (rst_n low, synchronous): time 0:00, no digits entered, buzzer pin
//   low, buzzer toggle phase high, output buffer empty.
//   Entry: clear, then four key digits (minute tens/units, second tens/units);
//   afterwards each unpaused tick counts down, and at 0:00 toggles the buzzer.
module mm_ss_countdown_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mmss_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] key_code, [8] paused
  input  logic [1:0]                      in_tuser,   // [1:0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mmss_pkg::OUT_DATA_W-1:0] out_tdata   // [5:0] minutes, [11:6] seconds,
                                                      // [12] done_res, [13] buzzer_pin,
                                                      // [16:14] digits_entered,
                                                      // [17] key_accepted
);

  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       phase_r, phase_nxt;
  logic       buzz_r, buzz_nxt;

  mmss_pkg::result_t res_nxt;
  mmss_pkg::result_t out_data_r, out_data_nxt;
  mmss_pkg::result_t skid_data_r, skid_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;

  logic       in_fire, out_fire;
  logic [7:0] key;
  logic       paused;
  logic [7:0] digit;
  logic       tens;
  logic       digit_ok;
  logic [5:0] add;
  logic       done;
  logic       accepted;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mmss_pkg::OUT_DATA_W - mmss_pkg::RESULT_W){1'b0}}, out_data_r};

  assign key    = in_tdata[7:0];
  assign paused = in_tdata[8];
  assign digit  = key - mmss_pkg::ASCII_ZERO;
  assign tens   = !pos_r[0];
  assign digit_ok = (pos_r < mmss_pkg::DIGIT_COUNT) && (key >= mmss_pkg::ASCII_ZERO) &&
                    (digit < (tens ? mmss_pkg::TENS_LIMIT : mmss_pkg::UNITS_LIMIT));
  // tens digit is at most 5, so x10 fits in 6 bits
  assign add = tens ? ({digit[2:0], 3'b000} + {2'b00, digit[2:0], 1'b0}) : digit[5:0];

  always_comb begin
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    buzz_nxt  = buzz_r;
    done      = 1'b0;
    accepted  = 1'b0;
    case (mmss_pkg::req_t'(in_tuser))
      mmss_pkg::REQ_TICK: begin
        if (!paused && pos_r >= mmss_pkg::DIGIT_COUNT) begin
          if (min_r == 6'd0 && sec_r == 6'd0) begin
            done      = 1'b1;
            buzz_nxt  = phase_r;
            phase_nxt = !phase_r;
          end else if (sec_r == 6'd0) begin
            min_nxt = min_r - 6'd1;
            sec_nxt = mmss_pkg::SEC_MAX;
          end else begin
            sec_nxt = sec_r - 6'd1;
          end
        end
      end
      mmss_pkg::REQ_KEY: begin
        if (digit_ok) begin
          if (pos_r < mmss_pkg::POS_SECONDS) begin
            min_nxt = min_r + add;
          end else begin
            sec_nxt = sec_r + add;
          end
          pos_nxt  = pos_r + 3'd1;
          accepted = 1'b1;
        end
      end
      mmss_pkg::REQ_CLEAR: begin
        min_nxt  = 6'd0;
        sec_nxt  = 6'd0;
        pos_nxt  = 3'd0;
        buzz_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    res_nxt.minutes        = min_nxt;
    res_nxt.seconds        = sec_nxt;
    res_nxt.done_res       = done;
    res_nxt.buzzer_pin     = buzz_nxt;
    res_nxt.digits_entered = pos_nxt;
    res_nxt.key_accepted   = accepted;
  end

  // Output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : res_nxt;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r        <= 6'd0;
      sec_r        <= 6'd0;
      pos_r        <= 3'd0;
      phase_r      <= 1'b1;
      buzz_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        min_r   <= min_nxt;
        sec_r   <= sec_nxt;
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        buzz_r  <= buzz_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mmss_pkg::DIGIT_COUNT)
    else $error("digit position out of range");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_key_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && accepted) |=> (pos_r == $past(pos_r) + 3'd1))
    else $error("accepted digit did not advance position");

  a_done_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && done) |=> (min_r == 6'd0 && sec_r == 6'd0 && phase_r != $past(phase_r)))
    else $error("done raised without zero time or phase toggle");

endmodule

// File: tb/mm_ss_countdown_timer_tb.sv
// Testbench for mm_ss_countdown_timer: digit entry, countdown, alarm and random sessions.
// A built-in timer predictor and a result queue check every output transfer.
// Depends on mmss_pkg and the mm_ss_countdown_timer RTL.
`timescale 1ns / 1ps

module mm_ss_countdown_timer_tb;
  import mmss_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] key_code, [8] paused
  logic [1:0]            in_tuser = '0;   // [1:0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [5:0] minutes, [11:6] seconds, [12] done_res,
                                          // [13] buzzer_pin, [16:14] digits_entered,
                                          // [17] key_accepted

  mm_ss_countdown_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // timer state as the predictor sees it
  logic [5:0] tm_minutes;
  logic [5:0] tm_seconds;
  logic [2:0] tm_pos;
  logic       tm_phase;
  logic       tm_level;

  result_t expected_results[$];
  int      error_count = 0;
  int      items_sent  = 0;
  bit      idle_en     = 1'b1;
  int      stall_left  = 0;
  int      quiet_cycles = 0;

  function automatic void timer_predict(req_t req, logic [7:0] key, logic paused);
    result_t    r;
    logic [7:0] val;
    logic [5:0] add;
    logic       tens;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (!paused && tm_pos >= DIGIT_COUNT) begin
          if (tm_minutes == 0 && tm_seconds == 0) begin
            r.done_res = 1'b1;
            tm_level   = tm_phase;
            tm_phase   = ~tm_phase;
          end else if (tm_seconds == 0) begin
            tm_minutes = tm_minutes - 6'd1;
            tm_seconds = SEC_MAX;
          end else begin
            tm_seconds = tm_seconds - 6'd1;
          end
        end
      end
      REQ_KEY: begin
        if (tm_pos < DIGIT_COUNT && key >= ASCII_ZERO) begin
          val  = key - ASCII_ZERO;
          tens = ~tm_pos[0];
          if (val < (tens ? TENS_LIMIT : UNITS_LIMIT)) begin
            add = tens ? 6'(val * UNITS_LIMIT) : val[5:0];
            if (tm_pos < POS_SECONDS) tm_minutes = tm_minutes + add;
            else tm_seconds = tm_seconds + add;
            tm_pos = tm_pos + 3'd1;
            r.key_accepted = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        tm_minutes = '0;
        tm_seconds = '0;
        tm_pos     = '0;
        tm_level   = 1'b0;
      end
      default: begin
      end
    endcase
    r.minutes        = tm_minutes;
    r.seconds        = tm_seconds;
    r.buzzer_pin     = tm_level;
    r.digits_entered = tm_pos;
    expected_results.push_back(r);
  endfunction

  // Returns right after the rising edge at which the transfer happened.
  task automatic send_item(req_t req, logic [7:0] key, logic paused);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {{(IN_DATA_W-9){1'b0}}, paused, key};
    do @(posedge clk); while (!in_tready);
    timer_predict(req, key, paused);
    items_sent++;
  endtask

  task automatic press(int digit);
    send_item(REQ_KEY, 8'(ASCII_ZERO + digit), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_digit_entry();
    send_item(REQ_TICK, 8'h00, 1'b0);       // tick during entry
    send_item(REQ_KEY, 8'h00, 1'b0);
    send_item(REQ_KEY, 8'hFF, 1'b1);
    send_item(REQ_KEY, 8'd47, 1'b0);        // just below '0'
    send_item(REQ_KEY, 8'd54, 1'b0);        // '6' as tens
    press(5);
    send_item(REQ_KEY, 8'd58, 1'b1);        // ':' as units
    press(9);
    press(6);
    press(5);
    press(9);
    send_item(REQ_TICK, 8'hFF, 1'b1);       // paused tick
    send_item(REQ_KEY, 8'd49, 1'b0);        // key while running
    send_item(REQ_NONE, 8'hFF, 1'b1);
    send_item(REQ_TICK, 8'h00, 1'b0);
  endtask

  task automatic test_alarm();
    send_item(REQ_CLEAR, 8'hFF, 1'b1);
    press(0);
    press(1);
    press(0);
    press(0);
    send_item(REQ_TICK, 8'h00, 1'b0);       // borrow from minutes
    send_item(REQ_CLEAR, 8'h00, 1'b0);
    press(0);
    press(0);
    press(0);
    press(1);
    repeat (3) send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_TICK, 8'h00, 1'b1);
    send_item(REQ_CLEAR, 8'h00, 1'b0);      // buzzer low, phase kept
  endtask

  // clear, four digits or fewer (some rejected keys mixed in), then ticks once all four are in
  task automatic test_sessions(int upto);
    int   digit[4];
    int   ndig;
    int   nticks;
    int   r;
    bit   short_run;
    while (items_sent < upto) begin
      short_run = ($urandom_range(0, 3) != 0);
      digit[0] = short_run ? 0 : $urandom_range(0, 5);
      digit[1] = short_run ? int'($urandom_range(0, 3) == 0) : $urandom_range(0, 9);
      digit[2] = short_run ? $urandom_range(0, 1) : $urandom_range(0, 5);
      digit[3] = $urandom_range(0, 9);
      send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
      for (int i = 0; i < ndig; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(REQ_KEY, 8'($urandom_range(0, 47)), 1'($urandom_range(0, 1)));
          end else begin
            send_item(REQ_KEY, 8'($urandom_range((i % 2 == 0) ? 54 : 58, 255)),
                      1'($urandom_range(0, 1)));
          end
        end
        press(digit[i]);
      end
      if (ndig == 4) begin
        nticks = short_run ? digit[1] * 60 + digit[2] * 10 + digit[3] + $urandom_range(0, 6)
                           : $urandom_range(0, 20);
        for (int t = 0; t < nticks; t++) begin
          r = $urandom_range(0, 15);
          case (r)
            0:       send_item(REQ_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            1:       send_item(REQ_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            2:       send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b1);
            default: send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
      end
    end
  endtask

  task automatic test_noise(int count);
    repeat (count) begin
      send_item(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("minutes", exp_r.minutes, got.minutes);
        check_field("seconds", exp_r.seconds, got.seconds);
        check_field("done_res", exp_r.done_res, got.done_res);
        check_field("buzzer_pin", exp_r.buzzer_pin, got.buzzer_pin);
        check_field("digits_entered", exp_r.digits_entered, got.digits_entered);
        check_field("key_accepted", exp_r.key_accepted, got.key_accepted);
      end
    end
  end

  // result-side backpressure in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("mm_ss_countdown_timer_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    tm_minutes = '0;
    tm_seconds = '0;
    tm_pos     = '0;
    tm_phase   = 1'b1;
    tm_level   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_digit_entry();
    test_alarm();
    test_sessions(1300);
    test_noise(250);
    idle_en = 1'b0;
    test_sessions(1800);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("mm_ss_countdown_timer_tb: clean");
    end else begin
      $display("mm_ss_countdown_timer_tb: errors");
    end
    $finish;
  end

endmodule
